[src/gita_pkg.sv]
// Shared types, constants and helpers of the greedy IoU track table.
// No dependencies; gita_arith and the track table refer to it by scoped names.
package gita_pkg;

   localparam logic [15:0] MATCH_THRESHOLD_RESET = 16'd19661;
   localparam logic [7:0]  MAX_LOST_RESET        = 8'd30;
   localparam logic [7:0]  MISS_MAX              = 8'd255;
   localparam logic [22:0] SPEED_MAX             = 23'h7FFFFF;
   localparam logic [19:0] DT_MIN                = 20'd1000;
   localparam logic [19:0] US_PER_S              = 20'd1000000;

   localparam logic [1:0] MODE_DET     = 2'd0;
   localparam logic [1:0] MODE_DET_END = 2'd1;
   localparam logic [1:0] MODE_END     = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   localparam logic [0:0] CSR_MATCH_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_MAX_LOST        = 1'b1;

   localparam logic [4:0] IOU_STEPS   = 5'd17;
   localparam logic [4:0] SQRT_STEPS  = 5'd29;
   localparam logic [4:0] SPEED_STEPS = 5'd25;

   typedef struct packed {
      logic [31:0] ident;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  cls;
      logic [15:0] score;
      logic [17:0] cx;
      logic [17:0] cy;
      logic [7:0]  misses;
      logic [22:0] speed;
   } track_rec_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  cls;
      logic [15:0] score;
   } det_rec_type;

   typedef struct packed {
      logic        start;
      logic        sqrt_op;
      logic [4:0]  steps;
      logic [35:0] rem_init;
      logic [57:0] shin;
      logic [33:0] den;
   } arith_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MSTART, S_TLAT, S_DRD, S_DLAT, S_IMUL, S_IAREA, S_IDIV, S_IWAIT,
      S_UPD, S_SQX, S_SQY, S_SQRT, S_SQW, S_SDIV, S_SDW, S_NSTART, S_NLAT,
      S_CRD, S_CLAT, S_ERD, S_ELAT
   } gita_state_type;

   function automatic logic [17:0] center2(input logic [15:0] pos, input logic [15:0] size);
      center2 = {1'b0, pos, 1'b0} + {2'b00, size};
   endfunction

endpackage

[src/gita_ram.sv]
// Simple dual-port memory with registered read data.
// Used for the track table, the detection buffer and the taken marks.
module gita_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/gita_arith.sv]
// Shared shift-subtract unit: restoring division or integer square root,
// one quotient or root bit per cycle. Depends on gita_pkg.
module gita_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  gita_pkg::arith_cmd_type cmd,
   output logic                    busy,
   output logic [28:0]             result
);

   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [35:0] rem_ff, rem_in;
   logic [57:0] shin_ff, shin_in;
   logic [33:0] den_ff, den_in;
   logic [28:0] quo_ff, quo_in;
   logic [35:0] opa, opb;
   logic [36:0] diff;
   logic        ge;

   always_comb begin
      if (sqrt_ff) begin
         opa = {rem_ff[33:0], shin_ff[57:56]};
         opb = {5'd0, quo_ff, 2'b01};
      end else begin
         opa = {rem_ff[34:0], shin_ff[57]};
         opb = {2'd0, den_ff};
      end
      diff = {1'b0, opa} - {1'b0, opb};
      ge   = !diff[36];

      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shin_in = shin_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.sqrt_op;
         cnt_in  = cmd.steps;
         rem_in  = cmd.rem_init;
         shin_in = cmd.shin;
         den_in  = cmd.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[35:0] : opa;
         quo_in  = {quo_ff[27:0], ge};
         shin_in = sqrt_ff ? {shin_ff[55:0], 2'b00} : {shin_ff[56:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      shin_ff <= shin_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign busy   = busy_ff;
   assign result = quo_ff;

endmodule

[src/greedy_iou_track_table.sv]
// Greedy IoU track table: a request that only carries a detection leaves the table idle and ready.
// Frame end with L tracks and D detections matches every track against the untaken detections
// (17-step IoU passes of the shared divide/square-root unit), then runs 29- and 25-step passes
// of that unit for each matched track, then opens tracks from the D detections, compacts the N
// tracks and emits from M kept tracks, waiting while results stall. One frame at a time.
// Reset clears control state only; memories are read only where written.
module greedy_iou_track_table #(
   parameter int MAX_TRACKS     = 64,
   parameter int MAX_DETECTIONS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_x, box_y, box_width, box_height, object_class, score, frame_interval_us
   input  logic [111:0] req_tdata,
   // mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // track_id, out_x, out_y, out_width, out_height, out_class, out_score, speed
   output logic [143:0] rsp_tdata,
   output logic         rsp_tlast,
   // dropped
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int TIW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int TCW = $clog2(MAX_TRACKS + 1);
   localparam int DIW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
   localparam int DCW = $clog2(MAX_DETECTIONS + 1);
   localparam int TRW = $bits(gita_pkg::track_rec_type);
   localparam int DRW = $bits(gita_pkg::det_rec_type);
   localparam logic [TCW-1:0] TRACK_FULL = TCW'(MAX_TRACKS);
   localparam logic [DCW-1:0] DET_FULL   = DCW'(MAX_DETECTIONS);

   gita_pkg::gita_state_type state_ff, state_in;
   logic [15:0]  thr_ff, thr_in;
   logic [7:0]   maxlost_ff, maxlost_in;
   logic [TCW-1:0] live_ff, live_in;
   logic [31:0]  nid_ff, nid_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic         ovf_ff, ovf_in;
   logic         ovalid_ff, ovalid_in;

   logic [19:0]  dt_ff, dt_in;
   logic [TCW-1:0] t_ff, t_in, k_ff, k_in, j_ff, j_in, nz_ff, nz_in;
   logic [DCW-1:0] i_ff, i_in;
   logic [DIW-1:0] bidx_ff, bidx_in;
   logic         bfound_ff, bfound_in;
   logic [16:0]  best_ff, best_in;
   gita_pkg::track_rec_type tr_ff, tr_in;
   gita_pkg::det_rec_type   dr_ff, dr_in, bdet_ff, bdet_in;
   logic [31:0]  trarea_ff, trarea_in, darea_ff, darea_in;
   logic [16:0]  iw_ff, iw_in, ih_ff, ih_in;
   logic [33:0]  inter_ff, inter_in;
   logic [17:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [35:0]  dsq_ff, dsq_in;
   logic [36:0]  dsum_ff, dsum_in;
   logic [48:0]  rmul_ff, rmul_in;
   logic [143:0] out_ff, out_in;
   logic         olast_ff, olast_in, odrop_ff, odrop_in;

   logic           tm_we, tm_re;
   logic [TIW-1:0] tm_waddr, tm_raddr;
   gita_pkg::track_rec_type tm_wrec, tm_rec;
   logic [TRW-1:0] tm_rdata;
   logic           dm_we, dm_re;
   logic [DIW-1:0] dm_waddr, dm_raddr;
   gita_pkg::det_rec_type dm_wrec, dm_rec;
   logic [DRW-1:0] dm_rdata;
   logic           km_we, km_wdata;
   logic [DIW-1:0] km_waddr;
   logic [0:0]     km_rdata;

   gita_pkg::arith_cmd_type arith_cmd;
   logic        arith_busy;
   logic [28:0] arith_result;

   gita_pkg::det_rec_type req_det;
   logic        accept;
   logic [15:0] x1, y1;
   logic [16:0] ax2, bx2, ay2, by2, x2, y2;
   logic [33:0] uni;
   logic [17:0] ncx, ncy;
   logic [33:0] quo_in;
   logic [24:0] spd;
   logic [35:0] dysq;

   assign req_det.x     = req_tdata[15:0];
   assign req_det.y     = req_tdata[31:16];
   assign req_det.w     = req_tdata[47:32];
   assign req_det.h     = req_tdata[63:48];
   assign req_det.cls   = req_tdata[71:64];
   assign req_det.score = req_tdata[87:72];

   assign req_tready = (state_ff == gita_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign tm_rec     = gita_pkg::track_rec_type'(tm_rdata);
   assign dm_rec     = gita_pkg::det_rec_type'(dm_rdata);

   gita_ram #(.WIDTH(TRW), .DEPTH(MAX_TRACKS), .AW(TIW)) u_tracks (
      .clock(clock), .we(tm_we), .waddr(tm_waddr), .wdata(TRW'(tm_wrec)),
      .re(tm_re), .raddr(tm_raddr), .rdata(tm_rdata)
   );

   gita_ram #(.WIDTH(DRW), .DEPTH(MAX_DETECTIONS), .AW(DIW)) u_dets (
      .clock(clock), .we(dm_we), .waddr(dm_waddr), .wdata(DRW'(dm_wrec)),
      .re(dm_re), .raddr(dm_raddr), .rdata(dm_rdata)
   );

   gita_ram #(.WIDTH(1), .DEPTH(MAX_DETECTIONS), .AW(DIW)) u_taken (
      .clock(clock), .we(km_we), .waddr(km_waddr), .wdata(km_wdata),
      .re(dm_re), .raddr(dm_raddr), .rdata(km_rdata)
   );

   gita_arith u_arith (
      .clock(clock), .reset(reset), .cmd(arith_cmd),
      .busy(arith_busy), .result(arith_result)
   );

   always_comb begin
      x1  = (tr_ff.x > dm_rec.x) ? tr_ff.x : dm_rec.x;
      y1  = (tr_ff.y > dm_rec.y) ? tr_ff.y : dm_rec.y;
      ax2 = {1'b0, tr_ff.x} + {1'b0, tr_ff.w};
      bx2 = {1'b0, dm_rec.x} + {1'b0, dm_rec.w};
      ay2 = {1'b0, tr_ff.y} + {1'b0, tr_ff.h};
      by2 = {1'b0, dm_rec.y} + {1'b0, dm_rec.h};
      x2  = (ax2 < bx2) ? ax2 : bx2;
      y2  = (ay2 < by2) ? ay2 : by2;
      uni = {2'b00, trarea_ff} + {2'b00, darea_ff} - inter_ff;
      ncx = gita_pkg::center2(bdet_ff.x, bdet_ff.w);
      ncy = gita_pkg::center2(bdet_ff.y, bdet_ff.h);
      quo_in = rmul_ff[48:15];
      spd = arith_result[24:0];
      dysq = dy_ff * dy_ff;

      state_in   = state_ff;
      thr_in     = thr_ff;
      maxlost_in = maxlost_ff;
      live_in    = live_ff;
      nid_in     = nid_ff;
      dcnt_in    = dcnt_ff;
      ovf_in     = ovf_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      dt_in      = dt_ff;
      t_in       = t_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      nz_in      = nz_ff;
      i_in       = i_ff;
      bidx_in    = bidx_ff;
      bfound_in  = bfound_ff;
      best_in    = best_ff;
      tr_in      = tr_ff;
      dr_in      = dr_ff;
      bdet_in    = bdet_ff;
      trarea_in  = trarea_ff;
      darea_in   = darea_ff;
      iw_in      = iw_ff;
      ih_in      = ih_ff;
      inter_in   = inter_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      dsq_in     = dsq_ff;
      dsum_in    = dsum_ff;
      rmul_in    = rmul_ff;
      out_in     = out_ff;
      olast_in   = olast_ff;
      odrop_in   = odrop_ff;

      tm_we    = 1'b0;
      tm_waddr = t_ff[TIW-1:0];
      tm_wrec  = tr_ff;
      tm_re    = 1'b0;
      tm_raddr = t_ff[TIW-1:0];
      dm_we    = 1'b0;
      dm_waddr = dcnt_ff[DIW-1:0];
      dm_wrec  = req_det;
      dm_re    = 1'b0;
      dm_raddr = i_ff[DIW-1:0];
      km_we    = 1'b0;
      km_waddr = dcnt_ff[DIW-1:0];
      km_wdata = 1'b0;
      arith_cmd = '0;

      if (csr_we) begin
         if (csr_index == gita_pkg::CSR_MATCH_THRESHOLD) begin
            thr_in = csr_wdata;
         end else begin
            maxlost_in = csr_wdata[7:0];
         end
      end

      unique case (state_ff)
         gita_pkg::S_IDLE: begin
            if (accept && req_tuser != gita_pkg::MODE_NONE) begin
               if (req_tuser == gita_pkg::MODE_DET || req_tuser == gita_pkg::MODE_DET_END) begin
                  if (dcnt_ff != DET_FULL) begin
                     dm_we   = 1'b1;
                     km_we   = 1'b1;
                     dcnt_in = dcnt_ff + DCW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_tuser == gita_pkg::MODE_DET_END || req_tuser == gita_pkg::MODE_END) begin
                  dt_in    = (req_tdata[107:88] < gita_pkg::DT_MIN) ? gita_pkg::DT_MIN
                                                                   : req_tdata[107:88];
                  t_in     = '0;
                  state_in = gita_pkg::S_MSTART;
               end
            end
         end
         gita_pkg::S_MSTART: begin
            if (t_ff == live_ff) begin
               i_in     = '0;
               state_in = gita_pkg::S_NSTART;
            end else begin
               tm_re    = 1'b1;
               state_in = gita_pkg::S_TLAT;
            end
         end
         gita_pkg::S_TLAT: begin
            tr_in     = tm_rec;
            trarea_in = tm_rec.w * tm_rec.h;
            i_in      = '0;
            bfound_in = 1'b0;
            best_in   = {1'b0, thr_ff};
            state_in  = gita_pkg::S_DRD;
         end
         gita_pkg::S_DRD: begin
            if (i_ff == dcnt_ff) begin
               state_in = gita_pkg::S_UPD;
            end else begin
               dm_re    = 1'b1;
               state_in = gita_pkg::S_DLAT;
            end
         end
         gita_pkg::S_DLAT: begin
            dr_in = dm_rec;
            iw_in = (x2 > {1'b0, x1}) ? x2 - {1'b0, x1} : 17'd0;
            ih_in = (y2 > {1'b0, y1}) ? y2 - {1'b0, y1} : 17'd0;
            if (km_rdata[0]) begin
               i_in     = i_ff + DCW'(1);
               state_in = gita_pkg::S_DRD;
            end else begin
               state_in = gita_pkg::S_IMUL;
            end
         end
         gita_pkg::S_IMUL: begin
            inter_in = iw_ff * ih_ff;
            state_in = gita_pkg::S_IAREA;
         end
         gita_pkg::S_IAREA: begin
            darea_in = dr_ff.w * dr_ff.h;
            state_in = gita_pkg::S_IDIV;
         end
         gita_pkg::S_IDIV: begin
            if (uni == 34'd0) begin
               i_in     = i_ff + DCW'(1);
               state_in = gita_pkg::S_DRD;
            end else begin
               arith_cmd.start    = 1'b1;
               arith_cmd.sqrt_op  = 1'b0;
               arith_cmd.steps    = gita_pkg::IOU_STEPS;
               arith_cmd.rem_init = {3'd0, inter_ff[33:1]};
               arith_cmd.shin     = {inter_ff[0], 57'd0};
               arith_cmd.den      = uni;
               state_in           = gita_pkg::S_IWAIT;
            end
         end
         gita_pkg::S_IWAIT: begin
            if (!arith_busy) begin
               if (arith_result[16:0] > best_ff) begin
                  best_in   = arith_result[16:0];
                  bidx_in   = i_ff[DIW-1:0];
                  bdet_in   = dr_ff;
                  bfound_in = 1'b1;
               end
               i_in     = i_ff + DCW'(1);
               state_in = gita_pkg::S_DRD;
            end
         end
         gita_pkg::S_UPD: begin
            if (!bfound_ff) begin
               tm_we = 1'b1;
               if (tr_ff.misses != gita_pkg::MISS_MAX) begin
                  tm_wrec.misses = tr_ff.misses + 8'd1;
               end
               t_in     = t_ff + TCW'(1);
               state_in = gita_pkg::S_MSTART;
            end else begin
               km_we        = 1'b1;
               km_waddr     = bidx_ff;
               km_wdata     = 1'b1;
               dx_in        = (tr_ff.cx > ncx) ? tr_ff.cx - ncx : ncx - tr_ff.cx;
               dy_in        = (tr_ff.cy > ncy) ? tr_ff.cy - ncy : ncy - tr_ff.cy;
               tr_in.x      = bdet_ff.x;
               tr_in.y      = bdet_ff.y;
               tr_in.w      = bdet_ff.w;
               tr_in.h      = bdet_ff.h;
               tr_in.cls    = bdet_ff.cls;
               tr_in.score  = bdet_ff.score;
               tr_in.cx     = ncx;
               tr_in.cy     = ncy;
               tr_in.misses = 8'd0;
               state_in     = gita_pkg::S_SQX;
            end
         end
         gita_pkg::S_SQX: begin
            dsq_in   = dx_ff * dx_ff;
            state_in = gita_pkg::S_SQY;
         end
         gita_pkg::S_SQY: begin
            dsum_in  = {1'b0, dsq_ff} + {1'b0, dysq};
            state_in = gita_pkg::S_SQRT;
         end
         gita_pkg::S_SQRT: begin
            arith_cmd.start    = 1'b1;
            arith_cmd.sqrt_op  = 1'b1;
            arith_cmd.steps    = gita_pkg::SQRT_STEPS;
            arith_cmd.rem_init = '0;
            arith_cmd.shin     = {1'b0, dsum_ff, 20'd0};
            arith_cmd.den      = '0;
            state_in           = gita_pkg::S_SQW;
         end
         gita_pkg::S_SQW: begin
            if (!arith_busy) begin
               rmul_in  = 49'(arith_result) * 49'(gita_pkg::US_PER_S);
               state_in = gita_pkg::S_SDIV;
            end
         end
         gita_pkg::S_SDIV: begin
            arith_cmd.start    = 1'b1;
            arith_cmd.sqrt_op  = 1'b0;
            arith_cmd.steps    = gita_pkg::SPEED_STEPS;
            arith_cmd.rem_init = {27'd0, quo_in[33:25]};
            arith_cmd.shin     = {quo_in[24:0], 33'd0};
            arith_cmd.den      = {14'd0, dt_ff};
            state_in           = gita_pkg::S_SDW;
         end
         gita_pkg::S_SDW: begin
            if (!arith_busy) begin
               tm_we         = 1'b1;
               tm_wrec.speed = (spd[24:23] != 2'b00) ? gita_pkg::SPEED_MAX : spd[22:0];
               t_in          = t_ff + TCW'(1);
               state_in      = gita_pkg::S_MSTART;
            end
         end
         gita_pkg::S_NSTART: begin
            if (i_ff == dcnt_ff) begin
               t_in     = '0;
               k_in     = '0;
               nz_in    = '0;
               state_in = gita_pkg::S_CRD;
            end else begin
               dm_re    = 1'b1;
               state_in = gita_pkg::S_NLAT;
            end
         end
         gita_pkg::S_NLAT: begin
            if (!km_rdata[0]) begin
               if (live_ff == TRACK_FULL) begin
                  ovf_in = 1'b1;
               end else begin
                  tm_we          = 1'b1;
                  tm_waddr       = live_ff[TIW-1:0];
                  tm_wrec.ident  = nid_ff;
                  tm_wrec.x      = dm_rec.x;
                  tm_wrec.y      = dm_rec.y;
                  tm_wrec.w      = dm_rec.w;
                  tm_wrec.h      = dm_rec.h;
                  tm_wrec.cls    = dm_rec.cls;
                  tm_wrec.score  = dm_rec.score;
                  tm_wrec.cx     = gita_pkg::center2(dm_rec.x, dm_rec.w);
                  tm_wrec.cy     = gita_pkg::center2(dm_rec.y, dm_rec.h);
                  tm_wrec.misses = 8'd0;
                  tm_wrec.speed  = 23'd0;
                  live_in        = live_ff + TCW'(1);
                  nid_in         = nid_ff + 32'd1;
               end
            end
            i_in     = i_ff + DCW'(1);
            state_in = gita_pkg::S_NSTART;
         end
         gita_pkg::S_CRD: begin
            if (t_ff == live_ff) begin
               live_in  = k_ff;
               t_in     = '0;
               j_in     = '0;
               state_in = gita_pkg::S_ERD;
            end else begin
               tm_re    = 1'b1;
               state_in = gita_pkg::S_CLAT;
            end
         end
         gita_pkg::S_CLAT: begin
            if (tm_rec.misses <= maxlost_ff) begin
               tm_we    = 1'b1;
               tm_waddr = k_ff[TIW-1:0];
               tm_wrec  = tm_rec;
               k_in     = k_ff + TCW'(1);
               if (tm_rec.misses == 8'd0) begin
                  nz_in = nz_ff + TCW'(1);
               end
            end
            t_in     = t_ff + TCW'(1);
            state_in = gita_pkg::S_CRD;
         end
         gita_pkg::S_ERD: begin
            if (t_ff == live_ff) begin
               dcnt_in  = '0;
               ovf_in   = 1'b0;
               state_in = gita_pkg::S_IDLE;
            end else begin
               tm_re    = 1'b1;
               state_in = gita_pkg::S_ELAT;
            end
         end
         gita_pkg::S_ELAT: begin
            if (tm_rec.misses != 8'd0) begin
               t_in     = t_ff + TCW'(1);
               state_in = gita_pkg::S_ERD;
            end else if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               out_in    = {1'b0, tm_rec.speed, tm_rec.score, tm_rec.cls, tm_rec.h,
                            tm_rec.w, tm_rec.y, tm_rec.x, tm_rec.ident};
               olast_in  = ((j_ff + TCW'(1)) == nz_ff);
               odrop_in  = ovf_ff;
               j_in      = j_ff + TCW'(1);
               t_in      = t_ff + TCW'(1);
               state_in  = gita_pkg::S_ERD;
            end
         end
         default: begin
            state_in = gita_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gita_pkg::S_IDLE;
         thr_ff     <= gita_pkg::MATCH_THRESHOLD_RESET;
         maxlost_ff <= gita_pkg::MAX_LOST_RESET;
         live_ff    <= '0;
         nid_ff     <= '0;
         dcnt_ff    <= '0;
         ovf_ff     <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         thr_ff     <= thr_in;
         maxlost_ff <= maxlost_in;
         live_ff    <= live_in;
         nid_ff     <= nid_in;
         dcnt_ff    <= dcnt_in;
         ovf_ff     <= ovf_in;
         ovalid_ff  <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff     <= dt_in;
      t_ff      <= t_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      nz_ff     <= nz_in;
      i_ff      <= i_in;
      bidx_ff   <= bidx_in;
      bfound_ff <= bfound_in;
      best_ff   <= best_in;
      tr_ff     <= tr_in;
      dr_ff     <= dr_in;
      bdet_ff   <= bdet_in;
      trarea_ff <= trarea_in;
      darea_ff  <= darea_in;
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      inter_ff  <= inter_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dsq_ff    <= dsq_in;
      dsum_ff   <= dsum_in;
      rmul_ff   <= rmul_in;
      out_ff    <= out_in;
      olast_ff  <= olast_in;
      odrop_ff  <= odrop_in;
   end

   assign rsp_tvalid   = ovalid_ff;
   assign rsp_tdata    = out_ff;
   assign rsp_tlast    = olast_ff;
   assign rsp_tuser[0] = odrop_ff;

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= TRACK_FULL)
      else $error("track count beyond table size");

   a_det_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= DET_FULL)
      else $error("detection count beyond buffer size");

   a_arith_start: assert property (@(posedge clock) disable iff (reset)
      arith_cmd.start |-> !arith_busy)
      else $error("arithmetic unit started while busy");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gita_pkg::S_ERD) |-> (j_ff <= nz_ff))
      else $error("more results than unmissed tracks");

endmodule
